>>> rtl/rrip_pkg.sv
// Shared types and constants for the RRIP replacement block.
package rrip_pkg;

  localparam int SETS        = 2048;
  localparam int SET_W       = $clog2(SETS);
  localparam int WAYS        = 16;
  localparam int WAY_W       = $clog2(WAYS);
  localparam int LEADER_SETS = 64;
  localparam int SEL_W       = 10;
  localparam int HIST        = 4;
  localparam int PTR_W       = $clog2(HIST);
  localparam int ADDR_W      = 64;
  localparam int DELTA_W     = 32;
  localparam int ROLL_W      = 5;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] RR_DISTANT = 2'd3;
  localparam logic [1:0] RR_LONG    = 2'd2;
  localparam logic [1:0] RR_NEAR    = 2'd0;
  localparam logic [SEL_W-1:0] SEL_MID = SEL_W'(1) << (SEL_W - 1);
  localparam logic [SEL_W-1:0] SEL_MAX = '1;

  typedef enum logic [1:0] {
    KIND_SRRIP    = 2'd0,
    KIND_BIMODAL  = 2'd1,
    KIND_FOLLOWER = 2'd2
  } kind_t;

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  // one classified transaction waiting in the queue
  typedef struct packed {
    op_t               op;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic              all_valid;
    logic [WAY_W-1:0]  first_invalid;
    logic [ADDR_W-1:0] address;
    logic              hit;
    logic              roll_zero;
    kind_t             kind;
  } item_t;

  // per-set state word
  typedef struct packed {
    logic [WAYS-1:0][1:0]          rr;
    logic [WAYS-1:0][1:0]          ru;
    logic [ADDR_W-1:0]             last_addr;
    logic [HIST-1:0][DELTA_W-1:0]  delta;
    logic [PTR_W-1:0]              ptr;
    logic [1:0]                    score;
  } set_state_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

>>> rtl/rrip_front.sv
// Front end: accepts transactions, classifies them and queues them.
module rrip_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [rrip_pkg::SET_W-1:0]  in_set_index,
  input  logic [rrip_pkg::WAY_W-1:0]  in_way_index,
  input  logic [rrip_pkg::WAYS-1:0]   in_valid_mask,
  input  logic [rrip_pkg::ADDR_W-1:0] in_address,
  input  logic                        in_hit,
  input  logic [rrip_pkg::ROLL_W-1:0] in_bimodal_roll,
  input  logic                        back_ready,
  input  logic                        pop,
  output rrip_pkg::q_head_t           head
);

  rrip_pkg::item_t q_r [rrip_pkg::QDEPTH];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  rrip_pkg::item_t cls;
  logic            push;

  always_comb begin
    cls.op            = rrip_pkg::op_t'(in_opcode);
    cls.set_index     = in_set_index;
    cls.way_index     = in_way_index;
    cls.address       = in_address;
    cls.hit           = in_hit;
    cls.roll_zero     = (in_bimodal_roll == '0);
    cls.all_valid     = &in_valid_mask;
    cls.first_invalid = '0;
    for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
      if (!in_valid_mask[w]) cls.first_invalid = rrip_pkg::WAY_W'(w);
    end
    if (32'(in_set_index) < rrip_pkg::LEADER_SETS / 2) cls.kind = rrip_pkg::KIND_SRRIP;
    else if (32'(in_set_index) < rrip_pkg::LEADER_SETS) cls.kind = rrip_pkg::KIND_BIMODAL;
    else cls.kind = rrip_pkg::KIND_FOLLOWER;
  end

  assign busy = (cnt_r == 2'(rrip_pkg::QDEPTH)) || !back_ready;
  assign push = start && !busy;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= cls;
        wp_r      <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/rrip_back.sv
// Back end: per-set state memory, clearing pass and the policy itself.
module rrip_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrip_pkg::q_head_t           head,
  output logic                        pop,
  output logic                        ready,
  output logic                        out_valid,
  output logic [rrip_pkg::WAY_W-1:0]  out_victim_way,
  output logic [1:0]                  out_insert_priority,
  output logic                        out_bypassed,
  output logic                        out_streaming
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t                     state_r;
  logic [rrip_pkg::SET_W:0]   clr_r;
  logic [rrip_pkg::SEL_W-1:0] sel_r, sel_nxt;
  rrip_pkg::item_t            item_r;
  rrip_pkg::set_state_t       mem [rrip_pkg::SETS];
  rrip_pkg::set_state_t       rd_r, st_nxt, rst_word;
  logic                       we;
  logic [rrip_pkg::SET_W-1:0] wa;
  rrip_pkg::set_state_t       wd;

  logic [rrip_pkg::WAY_W-1:0] vic;
  logic [1:0]                 prio, maxv, addv, score_n, ins;
  logic                       byp, s2, strm;
  logic [rrip_pkg::DELTA_W-1:0] dlt;

  assign pop   = (state_r == S_IDLE) && head.valid;
  assign ready = (state_r != S_CLEAR);

  always_comb begin
    rst_word           = '0;
    for (int w = 0; w < rrip_pkg::WAYS; w++) begin
      rst_word.rr[w] = rrip_pkg::RR_DISTANT;
      rst_word.ru[w] = 2'd1;
    end
  end

  always_comb begin
    st_nxt  = rd_r;
    sel_nxt = sel_r;
    vic = '0; prio = '0; byp = 1'b0; s2 = 1'b0;
    maxv = '0; addv = '0; score_n = rd_r.score; ins = '0; strm = 1'b0; dlt = '0;
    if (item_r.op == rrip_pkg::OP_QUERY) begin
      if (!item_r.all_valid) begin
        vic = item_r.first_invalid;
      end else begin
        for (int w = 0; w < rrip_pkg::WAYS; w++)
          if (rd_r.rr[w] > maxv) maxv = rd_r.rr[w];
        addv = rrip_pkg::RR_DISTANT - maxv;
        for (int w = 0; w < rrip_pkg::WAYS; w++) st_nxt.rr[w] = rd_r.rr[w] + addv;
        for (int w = rrip_pkg::WAYS - 1; w >= 0; w--)
          if (st_nxt.rr[w] == rrip_pkg::RR_DISTANT) vic = rrip_pkg::WAY_W'(w);
      end
    end else begin
      // stride detector
      if (rd_r.last_addr != '0)
        dlt = item_r.address[rrip_pkg::DELTA_W-1:0] - rd_r.last_addr[rrip_pkg::DELTA_W-1:0];
      st_nxt.delta[rd_r.ptr] = dlt;
      st_nxt.ptr       = rd_r.ptr + 1'b1;
      st_nxt.last_addr = item_r.address;
      strm = (st_nxt.delta[0] != '0);
      for (int i = 1; i < rrip_pkg::HIST; i++)
        if (st_nxt.delta[i] != st_nxt.delta[0]) strm = 1'b0;
      if (strm) begin
        if (rd_r.score != 2'd3) score_n = rd_r.score + 2'd1;
      end else begin
        if (rd_r.score != 2'd0) score_n = rd_r.score - 2'd1;
      end
      st_nxt.score = score_n;
      s2 = score_n[1];
      if (item_r.hit) begin
        st_nxt.rr[item_r.way_index] = rrip_pkg::RR_NEAR;
        if (rd_r.ru[item_r.way_index] != 2'd3)
          st_nxt.ru[item_r.way_index] = rd_r.ru[item_r.way_index] + 2'd1;
        prio = rrip_pkg::RR_NEAR;
      end else if (s2 && rd_r.ru[item_r.way_index] == 2'd0) begin
        st_nxt.rr[item_r.way_index] = rrip_pkg::RR_DISTANT;
        prio = rrip_pkg::RR_DISTANT;
        byp  = 1'b1;
      end else begin
        case (item_r.kind)
          rrip_pkg::KIND_SRRIP:   ins = rrip_pkg::RR_LONG;
          rrip_pkg::KIND_BIMODAL: ins = item_r.roll_zero ? rrip_pkg::RR_NEAR : rrip_pkg::RR_LONG;
          default: ins = (sel_r >= rrip_pkg::SEL_MID) ? rrip_pkg::RR_LONG :
                         (item_r.roll_zero ? rrip_pkg::RR_NEAR : rrip_pkg::RR_LONG);
        endcase
        if (rd_r.ru[item_r.way_index][1]) ins = rrip_pkg::RR_NEAR;
        else if (s2) ins = rrip_pkg::RR_DISTANT;
        st_nxt.rr[item_r.way_index] = ins;
        st_nxt.ru[item_r.way_index] = 2'd1;
        prio = ins;
        if (item_r.kind == rrip_pkg::KIND_SRRIP && sel_r != '0) sel_nxt = sel_r - 1'b1;
        if (item_r.kind == rrip_pkg::KIND_BIMODAL && sel_r != rrip_pkg::SEL_MAX)
          sel_nxt = sel_r + 1'b1;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = item_r.set_index;
    wd = st_nxt;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      wa = clr_r[rrip_pkg::SET_W-1:0];
      wd = rst_word;
    end else if (state_r == S_EXEC) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[head.item.set_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      sel_r     <= rrip_pkg::SEL_MID;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (rrip_pkg::SET_W+1)'(rrip_pkg::SETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            item_r  <= head.item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          sel_r               <= sel_nxt;
          out_valid           <= 1'b1;
          out_victim_way      <= vic;
          out_insert_priority <= prio;
          out_bypassed        <= byp;
          out_streaming       <= s2;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid && !pop) else $error("activity during clear");
  a_exec_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_EXEC)) else $error("popped item not executed");

endmodule

>>> rtl/rrip_replacement_stream_bypass.sv
// Top level: RRIP replacement with stream bypass, front queue and back executor.
//  channel  | handshake          | payload
//  input    | start / busy       | in_opcode .. in_bimodal_roll
//  result   | out_valid (strobe) | out_victim_way .. out_streaming
// The back end handles each transaction as a state read, then a compute and write.
// A two-entry queue lets new transactions in while the back end works.
// After reset a clearing pass writes every set; busy stays high.
// Results appear one cycle each; the receiver cannot stall.
module rrip_replacement_stream_bypass (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [rrip_pkg::SET_W-1:0]  in_set_index,
  input  logic [rrip_pkg::WAY_W-1:0]  in_way_index,
  input  logic [rrip_pkg::WAYS-1:0]   in_valid_mask,
  input  logic [rrip_pkg::ADDR_W-1:0] in_address,
  input  logic                        in_hit,
  input  logic [rrip_pkg::ROLL_W-1:0] in_bimodal_roll,
  output logic                        out_valid,
  output logic [rrip_pkg::WAY_W-1:0]  out_victim_way,
  output logic [1:0]                  out_insert_priority,
  output logic                        out_bypassed,
  output logic                        out_streaming
);

  rrip_pkg::q_head_t head;
  logic              pop, ready;

  rrip_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_set_index, .in_way_index, .in_valid_mask,
    .in_address, .in_hit, .in_bimodal_roll,
    .back_ready(ready), .pop, .head
  );

  rrip_back u_back (
    .clk, .rst_n, .head, .pop, .ready,
    .out_valid, .out_victim_way, .out_insert_priority,
    .out_bypassed, .out_streaming
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the RRIP replacement block with stream bypass.
module testbench;

  typedef struct {
    logic                        op;
    logic [rrip_pkg::SET_W-1:0]  set_index;
    logic [rrip_pkg::WAY_W-1:0]  way_index;
    logic [rrip_pkg::WAYS-1:0]   valid_mask;
    logic [rrip_pkg::ADDR_W-1:0] address;
    logic                        hit;
    logic [rrip_pkg::ROLL_W-1:0] roll;
  } access_t;

  typedef struct {
    logic [rrip_pkg::WAY_W-1:0] victim;
    logic [1:0]                 prio;
    logic                       byp;
    logic                       strm;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [rrip_pkg::SET_W-1:0] in_set_index = '0;
  logic [rrip_pkg::WAY_W-1:0] in_way_index = '0;
  logic [rrip_pkg::WAYS-1:0] in_valid_mask = '0;
  logic [rrip_pkg::ADDR_W-1:0] in_address = '0;
  logic in_hit = 1'b0;
  logic [rrip_pkg::ROLL_W-1:0] in_bimodal_roll = '0;
  logic out_valid;
  logic [rrip_pkg::WAY_W-1:0] out_victim_way;
  logic [1:0] out_insert_priority;
  logic out_bypassed;
  logic out_streaming;

  rrip_replacement_stream_bypass dut (.*);

  // shadow copy of the policy state
  logic [1:0]                   m_rr    [rrip_pkg::SETS][rrip_pkg::WAYS];
  logic [1:0]                   m_ru    [rrip_pkg::SETS][rrip_pkg::WAYS];
  logic [rrip_pkg::ADDR_W-1:0]  m_last  [rrip_pkg::SETS];
  logic [rrip_pkg::DELTA_W-1:0] m_delta [rrip_pkg::SETS][rrip_pkg::HIST];
  logic [rrip_pkg::PTR_W-1:0]   m_ptr   [rrip_pkg::SETS];
  logic [1:0]                   m_score [rrip_pkg::SETS];
  logic [rrip_pkg::SEL_W-1:0]   m_sel;

  access_t   pending_q[$];
  decision_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_seen = 0, n_byp = 0, n_strm = 0;
  bit quiet = 1'b0;
  bit hold = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic decision_t predict_replacement(access_t a);
    decision_t d;
    logic [1:0] mx;
    logic [rrip_pkg::DELTA_W-1:0] dl;
    logic strm;
    logic [1:0] ins, bim;
    rrip_pkg::kind_t kd;
    int s, w;
    bit found;
    d = '{default: '0};
    s = a.set_index;
    w = a.way_index;
    if (a.op == rrip_pkg::OP_QUERY) begin
      found = 1'b0;
      for (int i = 0; i < rrip_pkg::WAYS; i++)
        if (!found && !a.valid_mask[i]) begin
          d.victim = rrip_pkg::WAY_W'(i); found = 1'b1;
        end
      if (!found) begin
        mx = '0;
        for (int i = 0; i < rrip_pkg::WAYS; i++) if (m_rr[s][i] > mx) mx = m_rr[s][i];
        for (int i = 0; i < rrip_pkg::WAYS; i++)
          m_rr[s][i] = m_rr[s][i] + (rrip_pkg::RR_DISTANT - mx);
        for (int i = rrip_pkg::WAYS - 1; i >= 0; i--)
          if (m_rr[s][i] == rrip_pkg::RR_DISTANT) d.victim = rrip_pkg::WAY_W'(i);
      end
      return d;
    end
    dl = (m_last[s] == 0) ? '0 : rrip_pkg::DELTA_W'(a.address - m_last[s]);
    m_delta[s][m_ptr[s]] = dl;
    m_ptr[s] = m_ptr[s] + 1'b1;
    m_last[s] = a.address;
    strm = (m_delta[s][0] != 0);
    for (int i = 1; i < rrip_pkg::HIST; i++) if (m_delta[s][i] != m_delta[s][0]) strm = 1'b0;
    if (strm) begin
      if (m_score[s] < 3) m_score[s]++;
    end else if (m_score[s] > 0) begin
      m_score[s]--;
    end
    strm = m_score[s] >= 2;
    d.strm = strm;
    if (a.hit) begin
      m_rr[s][w] = rrip_pkg::RR_NEAR;
      if (m_ru[s][w] < 3) m_ru[s][w]++;
    end else if (strm && m_ru[s][w] == 0) begin
      m_rr[s][w] = rrip_pkg::RR_DISTANT;
      d.prio = rrip_pkg::RR_DISTANT;
      d.byp = 1'b1;
    end else begin
      kd = (s < rrip_pkg::LEADER_SETS / 2) ? rrip_pkg::KIND_SRRIP :
           (s < rrip_pkg::LEADER_SETS) ? rrip_pkg::KIND_BIMODAL : rrip_pkg::KIND_FOLLOWER;
      bim = (a.roll == 0) ? rrip_pkg::RR_NEAR : rrip_pkg::RR_LONG;
      if (kd == rrip_pkg::KIND_SRRIP) ins = rrip_pkg::RR_LONG;
      else if (kd == rrip_pkg::KIND_BIMODAL) ins = bim;
      else ins = (m_sel >= rrip_pkg::SEL_MID) ? rrip_pkg::RR_LONG : bim;
      if (m_ru[s][w] >= 2) ins = rrip_pkg::RR_NEAR;
      else if (strm) ins = rrip_pkg::RR_DISTANT;
      m_rr[s][w] = ins;
      m_ru[s][w] = 2'd1;
      d.prio = ins;
      if (kd == rrip_pkg::KIND_SRRIP && m_sel > 0) m_sel--;
      else if (kd == rrip_pkg::KIND_BIMODAL && m_sel < rrip_pkg::SEL_MAX) m_sel++;
    end
    return d;
  endfunction

  function automatic access_t mk(logic op, int s, int w, logic [rrip_pkg::WAYS-1:0] m,
                                 logic [rrip_pkg::ADDR_W-1:0] ad, logic h, int r);
    access_t a;
    a.op = op;
    a.set_index = rrip_pkg::SET_W'(s);
    a.way_index = rrip_pkg::WAY_W'(w);
    a.valid_mask = m;
    a.address = ad;
    a.hit = h;
    a.roll = rrip_pkg::ROLL_W'(r);
    return a;
  endfunction

  function automatic logic [rrip_pkg::ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // driver
  always @(posedge clk) begin
    bit take;
    take = rst_n && start && !busy;
    if (take) begin
      access_t a;
      a = '{op: in_opcode, set_index: in_set_index, way_index: in_way_index,
            valid_mask: in_valid_mask, address: in_address, hit: in_hit,
            roll: in_bimodal_roll};
      expected_q.push_back(predict_replacement(a));
      n_sent++;
    end
    if (!rst_n || (start && !take)) begin
      // keep holding the current transaction
    end else if (pending_q.size() == 0 || hold ||
                 (pending_q[0].op === 1'bx) ||
                 (!quiet && $urandom_range(99) < 14)) begin
      start <= 1'b0;
    end else if (pending_q[0].set_index === 'x) begin
      start <= 1'b0;
    end else begin
      access_t a;
      a = pending_q.pop_front();
      start <= 1'b1;
      in_opcode <= a.op;
      in_set_index <= a.set_index;
      in_way_index <= a.way_index;
      in_valid_mask <= a.valid_mask;
      in_address <= a.address;
      in_hit <= a.hit;
      in_bimodal_roll <= a.roll;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction");
        errors++;
      end else begin
        decision_t e;
        e = expected_q.pop_front();
        n_seen++;
        if (e.byp) n_byp++;
        if (e.strm) n_strm++;
        if (out_victim_way !== e.victim) begin
          $error("victim_way exp %0d got %0d", e.victim, out_victim_way); errors++;
        end
        if (out_insert_priority !== e.prio) begin
          $error("insert_priority exp %0d got %0d", e.prio, out_insert_priority); errors++;
        end
        if (out_bypassed !== e.byp) begin
          $error("bypassed exp %0d got %0d", e.byp, out_bypassed); errors++;
        end
        if (out_streaming !== e.strm) begin
          $error("streaming exp %0d got %0d", e.strm, out_streaming); errors++;
        end
      end
    end
  end

  task automatic stream_run(int s, int len, int stride, bit wellformed);
    logic [rrip_pkg::ADDR_W-1:0] ad;
    ad = rand64() | 64'h1;
    for (int i = 0; i < len; i++) begin
      int w;
      w = $urandom_range(rrip_pkg::WAYS - 1);
      pending_q.push_back(mk(rrip_pkg::OP_UPDATE, s, w, '0, ad, $urandom_range(3) == 0,
                             $urandom_range(31)));
      if ($urandom_range(2) == 0)
        pending_q.push_back(mk(rrip_pkg::OP_QUERY, s, 0, $urandom_range(3) == 0 ?
                               rrip_pkg::WAYS'($urandom()) : '1, rand64(), 1'b0, 0));
      ad = wellformed ? ad + stride : rand64();
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < rrip_pkg::SETS; s++) begin
      for (int w = 0; w < rrip_pkg::WAYS; w++) begin
        m_rr[s][w] = rrip_pkg::RR_DISTANT; m_ru[s][w] = 2'd1;
      end
      for (int i = 0; i < rrip_pkg::HIST; i++) m_delta[s][i] = '0;
      m_last[s] = '0; m_ptr[s] = '0; m_score[s] = '0;
    end
    m_sel = rrip_pkg::SEL_MID;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, both ops, leaders and followers
    pending_q.push_back(mk(rrip_pkg::OP_QUERY, 0, 0, '0, '0, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_QUERY, 2047, 15, '1, '1, 1'b1, 31));
    pending_q.push_back(mk(rrip_pkg::OP_QUERY, 5, 0, 16'h7fff, '0, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 0, 0, '0, 64'h100, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 40, 15, '1, '1, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 40, 14, '0, 64'h10, 1'b0, 31));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 2047, 3, '0, 64'h8000_0000_0000_0000,
                           1'b1, 31));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 2047, 3, '0, 64'h8000_0000_0000_0040,
                           1'b1, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 2047, 3, '0, 64'h8000_0000_0000_0080,
                           1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 100, 7, '0, 64'h55, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 31, 1, '0, 64'h33, 1'b0, 5));
    pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 32, 1, '0, 64'h44, 1'b0, 5));
    pending_q.push_back(mk(rrip_pkg::OP_QUERY, 2047, 0, '1, '0, 1'b0, 0));
    pending_q.push_back(mk(rrip_pkg::OP_QUERY, 100, 0, '1, '0, 1'b0, 0));
    // constant stride drives the score up; misses then insert at distant priority
    for (int i = 0; i < 8; i++)
      pending_q.push_back(mk(rrip_pkg::OP_UPDATE, 9, 2, '0, 64'h1000 + 64 * i, 1'b0, 1));
    wait_drained();

    // random: mostly stride streams, some noise, leader sets favored
    quiet = 1'b1;
    while (n_sent < 1250) begin
      int s, pick;
      if (n_sent > 400) quiet = 1'b0;
      pick = $urandom_range(9);
      s = (pick < 4) ? $urandom_range(rrip_pkg::LEADER_SETS - 1) :
          (pick < 7) ? $urandom_range(rrip_pkg::LEADER_SETS + 15, rrip_pkg::LEADER_SETS) :
                       $urandom_range(rrip_pkg::SETS - 1);
      stream_run(s, $urandom_range(12, 3),
                 ($urandom_range(3) == 0) ? $urandom() : 64 * $urandom_range(4),
                 $urandom_range(4) != 0);
      if (n_sent > 700 && n_sent < 730) begin
        wait_drained();
        hold = 1'b1;
        repeat (3) @(posedge clk);
        hold = 1'b0;
      end
      while (pending_q.size() > 20) @(posedge clk);
    end
    wait_drained();

    $display("covered %0d transactions, %0d results, %0d bypasses, %0d streaming",
             n_sent, n_seen, n_byp, n_strm);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/rrip_pkg.sv
rtl/rrip_front.sv
rtl/rrip_back.sv
rtl/rrip_replacement_stream_bypass.sv
sim/testbench.sv
